>>> rtl/kli_pkg.sv
package kli_pkg;

    localparam int DEF_KEY_CHARS    = 16;
    localparam int DEF_BUCKET_COUNT = 1024;
    localparam int DEF_MAX_KEYS     = 256;
    localparam int DEF_OCC_MAX      = 64;

    localparam logic [1:0] ACT_KEY   = 2'd0;
    localparam logic [1:0] ACT_TEXT  = 2'd1;
    localparam logic [1:0] ACT_QUERY = 2'd2;
    localparam logic [1:0] ACT_READ  = 2'd3;

    localparam logic [2:0] ST_ADDED    = 3'd0;
    localparam logic [2:0] ST_DUP      = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_FOUND    = 3'd4;
    localparam logic [2:0] ST_NOTFOUND = 3'd5;
    localparam logic [2:0] ST_READOK   = 3'd6;
    localparam logic [2:0] ST_RANGE    = 3'd7;

    localparam logic [31:0] HASH_INIT     = 32'd5381;
    localparam logic [7:0]  CH_NEWLINE    = 8'h0A;
    localparam logic [7:0]  CH_UNDERSCORE = 8'h5F;
    localparam logic [15:0] LINE_MAX      = 16'hFFFF;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] char_byte;
        logic       last;
        logic [7:0] entry_slot;
        logic [5:0] occ_index;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  slot;
        logic [6:0]  occ_count;
        logic [15:0] line_number;
        logic        overflowed;
    } t_out;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h61 && c <= 8'h7A) || (c == CH_UNDERSCORE);
    endfunction

endpackage

>>> rtl/keyword_line_indexer.sv
// Text byte: taken while idle; a byte that ends a word then hashes it, waits for the bucket
// head, compares one chained slot a cycle and writes back.
// Keyword/query end: normalise, hash unless empty, bucket read, chain compare, resolve.
// Occurrence read: read, then load the output; one item at a time, no new beat till done.
// Reset: synchronous, active low; the bucket memory is then swept clear, one entry a
// cycle, before the first beat is taken.
module keyword_line_indexer #(
    parameter int KEY_CHARS    = kli_pkg::DEF_KEY_CHARS,
    parameter int BUCKET_COUNT = kli_pkg::DEF_BUCKET_COUNT,
    parameter int MAX_KEYS     = kli_pkg::DEF_MAX_KEYS,
    parameter int OCC_MAX      = kli_pkg::DEF_OCC_MAX
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  kli_pkg::t_in  i_in_data,
    output logic          o_in_ready,
    output logic          o_out_valid,
    output kli_pkg::t_out o_out_data,
    input  logic          i_out_ready
);

    localparam int KB  = KEY_CHARS * 8;
    localparam int LW  = $clog2(KEY_CHARS + 1);
    localparam int SW  = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int UW  = $clog2(MAX_KEYS + 1);
    localparam int CW  = $clog2(OCC_MAX + 1);
    localparam int NBL = $clog2(BUCKET_COUNT);
    localparam int HW  = (NBL > 0) ? NBL : 1;
    localparam int OD  = MAX_KEYS * OCC_MAX;
    localparam int AW  = (OD > 1) ? $clog2(OD) : 1;

    // one slot entry: normalised key (zero padded), its length, chain link, occurrences
    typedef struct packed {
        logic [KB-1:0] key;
        logic [LW-1:0] len;
        logic          cvalid;
        logic [SW-1:0] cnext;
        logic [CW-1:0] total;
        logic          dropped;
    } t_slot;

    typedef struct packed {
        logic          valid;
        logic [SW-1:0] head;
    } t_bkt;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_NORM, S_HASH, S_BWAIT, S_SCMP, S_RESOLVE, S_RDADR, S_RDCHK
    } t_state;

    typedef enum logic [1:0] {M_FLUSH, M_KEY, M_QUERY} t_mode;

    t_state        r_state;
    t_mode         r_mode;
    logic [HW-1:0] r_clr;
    logic          r_ovalid;
    kli_pkg::t_out r_out;
    logic [UW-1:0] r_keys_used;
    logic [15:0]   r_line;
    logic [15:0]   r_occ_line;
    logic [KB-1:0] r_tok;
    logic [LW-1:0] r_tlen;
    logic [KB-1:0] r_str;
    logic [LW-1:0] r_slen;
    logic [KB-1:0] r_key;
    logic [LW-1:0] r_klen;
    logic [LW-1:0] r_idx;
    logic [HW-1:0] r_h;
    logic [SW-1:0] r_cur;
    logic [SW-1:0] r_slot;
    logic          r_found;
    t_slot         r_sent;
    logic [SW-1:0] r_rslot;
    logic [7:0]    r_reslot;
    logic [5:0]    r_ridx;

    // memories and their registered read data
    t_bkt          r_bkt_mem [BUCKET_COUNT];
    t_slot         r_slot_mem [MAX_KEYS];
    logic [15:0]   r_occ_mem [OD];
    t_bkt          r_bq;
    t_slot         r_sq;
    logic [15:0]   r_oq;

    logic          w_ofree;
    logic          w_oload;
    logic [7:0]    w_c;
    logic          w_word;
    logic [KB-1:0] w_tok_new;
    logic [LW-1:0] w_tlen_new;
    logic [KB-1:0] w_tok_mask;
    logic          w_flush_tok;
    logic [KB-1:0] w_str_new;
    logic [LW-1:0] w_slen_new;
    logic [LW-1:0] w_st;
    logic [LW-1:0] w_en;
    logic          w_go;
    logic [KB-1:0] w_shift;
    logic [LW-1:0] w_nlen;
    logic [KB-1:0] w_norm;
    logic [7:0]    w_hbyte;
    logic [HW-1:0] w_hnext;
    logic [HW-1:0] w_bra;
    logic          w_match;
    logic [SW-1:0] w_sra;
    logic [AW-1:0] w_ora;
    logic [AW-1:0] w_owa;
    logic          w_res_go;
    logic          w_insert;
    logic          w_flush_upd;
    logic          w_room;
    logic          w_bwe;
    logic [HW-1:0] w_bwa;
    t_bkt          w_bwd;
    logic          w_swe;
    logic [SW-1:0] w_swa;
    t_slot         w_swd;
    logic          w_rd_ok;
    kli_pkg::t_out w_res_out;
    kli_pkg::t_out w_rd_out;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;
    assign w_ofree     = !r_ovalid || i_out_ready;
    assign w_c         = i_in_data.char_byte;
    assign w_word      = kli_pkg::is_word(w_c);

    // text: append a word character, lowercased, up to KEY_CHARS
    always_comb begin
        w_tok_new  = r_tok;
        w_tlen_new = r_tlen;
        if (w_word && (r_tlen < LW'(KEY_CHARS))) begin
            w_tok_new[r_tlen*8 +: 8] = kli_pkg::to_lower(w_c);
            w_tlen_new               = r_tlen + 1'b1;
        end
        for (int i = 0; i < KEY_CHARS; i++) begin
            w_tok_mask[i*8 +: 8] = (LW'(i) < w_tlen_new) ? w_tok_new[i*8 +: 8] : 8'd0;
        end
    end

    // a word ends on a non-word byte, or on the flush marker
    assign w_flush_tok = (i_in_data.action == kli_pkg::ACT_TEXT) &&
                         (w_word ? i_in_data.last : (r_tlen != '0));

    // keyword/query: store raw bytes, drop zero bytes and bytes past KEY_CHARS
    always_comb begin
        w_str_new  = r_str;
        w_slen_new = r_slen;
        if ((w_c != 8'd0) && (r_slen < LW'(KEY_CHARS))) begin
            w_str_new[r_slen*8 +: 8] = w_c;
            w_slen_new               = r_slen + 1'b1;
        end
    end

    // trim leading and trailing whitespace, lowercase, zero pad; r_klen holds the raw length
    always_comb begin
        w_st = '0;
        w_go = 1'b1;
        for (int i = 0; i < KEY_CHARS; i++) begin
            if (w_go && (LW'(i) < r_klen) && kli_pkg::is_space(r_str[i*8 +: 8])) begin
                w_st = LW'(i + 1);
            end else begin
                w_go = 1'b0;
            end
        end
        w_en = w_st;
        for (int i = 0; i < KEY_CHARS; i++) begin
            if ((LW'(i) < r_klen) && (LW'(i) >= w_st) &&
                !kli_pkg::is_space(r_str[i*8 +: 8])) begin
                w_en = LW'(i + 1);
            end
        end
        w_nlen  = w_en - w_st;
        w_shift = r_str >> {w_st, 3'b000};
        for (int i = 0; i < KEY_CHARS; i++) begin
            w_norm[i*8 +: 8] = (LW'(i) < w_nlen) ? kli_pkg::to_lower(w_shift[i*8 +: 8]) : 8'd0;
        end
    end

    // djb2, one character a cycle; only the low bits matter for a power-of-two table
    assign w_hbyte = r_key[r_idx*8 +: 8];
    assign w_hnext = HW'({r_h, 5'b00000}) + r_h + HW'(w_hbyte);
    assign w_bra   = (NBL == 0) ? '0 : r_h;

    assign w_match = (r_sq.len == r_klen) && (r_sq.key == r_key);

    // slot read address: bucket head, then chain link, else the read request
    always_comb begin
        case (r_state)
            S_BWAIT: w_sra = r_bq.head;
            S_SCMP:  w_sra = r_sq.cnext;
            default: w_sra = r_rslot;
        endcase
    end

    assign w_ora = AW'(r_rslot) * AW'(OCC_MAX) + AW'(r_ridx);
    assign w_owa = AW'(r_slot) * AW'(OCC_MAX) + AW'(r_sent.total);

    assign w_res_go    = (r_state == S_RESOLVE) && ((r_mode == M_FLUSH) || w_ofree);
    assign w_insert    = w_res_go && (r_mode == M_KEY) && (r_klen != '0) && !r_found &&
                         (r_keys_used < UW'(MAX_KEYS));
    assign w_flush_upd = w_res_go && (r_mode == M_FLUSH) && r_found;
    assign w_room      = 32'(r_sent.total) < OCC_MAX;

    // a new result enters the output register this cycle
    assign w_oload = (w_res_go && (r_mode != M_FLUSH)) || ((r_state == S_RDCHK) && w_ofree);

    // write-back: sweep, new key at the head of its chain, or occurrence update
    always_comb begin
        w_bwe = 1'b0;
        w_bwa = r_clr;
        w_bwd = '0;
        if (r_state == S_CLR) begin
            w_bwe = 1'b1;
        end else if (w_insert) begin
            w_bwe      = 1'b1;
            w_bwa      = w_bra;
            w_bwd.valid = 1'b1;
            w_bwd.head  = SW'(r_keys_used);
        end

        w_swe = w_insert || w_flush_upd;
        w_swa = w_insert ? SW'(r_keys_used) : r_slot;
        w_swd = r_sent;
        if (w_insert) begin
            w_swd.key     = r_key;
            w_swd.len     = r_klen;
            w_swd.cvalid  = r_bq.valid;
            w_swd.cnext   = r_bq.head;
            w_swd.total   = '0;
            w_swd.dropped = 1'b0;
        end else if (w_room) begin
            w_swd.total = r_sent.total + 1'b1;
        end else begin
            w_swd.dropped = 1'b1;
        end
    end

    // result of a keyword or query end
    always_comb begin
        w_res_out = '0;
        if (r_mode == M_QUERY) begin
            if (r_found) begin
                w_res_out.status     = kli_pkg::ST_FOUND;
                w_res_out.slot       = 8'(r_slot);
                w_res_out.occ_count  = 7'(r_sent.total);
                w_res_out.overflowed = r_sent.dropped;
            end else begin
                w_res_out.status = kli_pkg::ST_NOTFOUND;
            end
        end else if (r_klen == '0) begin
            w_res_out.status = kli_pkg::ST_EMPTY;
        end else if (r_found) begin
            w_res_out.status     = kli_pkg::ST_DUP;
            w_res_out.slot       = 8'(r_slot);
            w_res_out.occ_count  = 7'(r_sent.total);
            w_res_out.overflowed = r_sent.dropped;
        end else if (r_keys_used >= UW'(MAX_KEYS)) begin
            w_res_out.status = kli_pkg::ST_FULL;
        end else begin
            w_res_out.status = kli_pkg::ST_ADDED;
            w_res_out.slot   = 8'(r_keys_used);
        end
    end

    // result of an occurrence read
    assign w_rd_ok = (32'(r_reslot) < 32'(r_keys_used)) &&
                     (32'(r_ridx) < 32'(r_sq.total)) && (32'(r_ridx) < OCC_MAX);

    always_comb begin
        w_rd_out = '0;
        if (w_rd_ok) begin
            w_rd_out.status      = kli_pkg::ST_READOK;
            w_rd_out.slot        = r_reslot;
            w_rd_out.occ_count   = 7'(r_sq.total);
            w_rd_out.line_number = r_oq;
            w_rd_out.overflowed  = r_sq.dropped;
        end else begin
            w_rd_out.status = kli_pkg::ST_RANGE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_bwe) begin
            r_bkt_mem[w_bwa] <= w_bwd;
        end
        r_bq <= r_bkt_mem[w_bra];
    end

    always_ff @(posedge i_clk) begin
        if (w_swe) begin
            r_slot_mem[w_swa] <= w_swd;
        end
        r_sq <= r_slot_mem[w_sra];
    end

    always_ff @(posedge i_clk) begin
        if (w_flush_upd && w_room) begin
            r_occ_mem[w_owa] <= r_occ_line;
        end
        r_oq <= r_occ_mem[w_ora];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr       <= '0;
            r_ovalid    <= 1'b0;
            r_keys_used <= '0;
            r_line      <= 16'd1;
            r_tlen      <= '0;
            r_slen      <= '0;
        end else begin
            // drop the result once taken, unless a new one loads below
            if (r_ovalid && i_out_ready && !w_oload) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == HW'(BUCKET_COUNT - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        case (i_in_data.action)
                            kli_pkg::ACT_TEXT: begin
                                r_tok  <= w_tok_new;
                                r_tlen <= w_flush_tok ? '0 : w_tlen_new;
                                // the word before a newline takes the old line number
                                if (!w_word && (w_c == kli_pkg::CH_NEWLINE) &&
                                    (r_line != kli_pkg::LINE_MAX)) begin
                                    r_line <= r_line + 16'd1;
                                end
                                if (w_flush_tok) begin
                                    r_key      <= w_tok_mask;
                                    r_klen     <= w_tlen_new;
                                    r_mode     <= M_FLUSH;
                                    r_found    <= 1'b0;
                                    r_occ_line <= r_line;
                                    r_h        <= HW'(kli_pkg::HASH_INIT);
                                    r_idx      <= '0;
                                    r_state    <= S_HASH;
                                end
                            end
                            kli_pkg::ACT_READ: begin
                                r_rslot  <= SW'(i_in_data.entry_slot);
                                r_reslot <= i_in_data.entry_slot;
                                r_ridx   <= i_in_data.occ_index;
                                r_state  <= S_RDADR;
                            end
                            default: begin
                                r_str <= w_str_new;
                                if (i_in_data.last) begin
                                    r_klen  <= w_slen_new;
                                    r_slen  <= '0;
                                    r_mode  <= (i_in_data.action == kli_pkg::ACT_QUERY) ?
                                               M_QUERY : M_KEY;
                                    r_found <= 1'b0;
                                    r_state <= S_NORM;
                                end else begin
                                    r_slen <= w_slen_new;
                                end
                            end
                        endcase
                    end
                end
                S_NORM: begin
                    r_key   <= w_norm;
                    r_klen  <= w_nlen;
                    r_h     <= HW'(kli_pkg::HASH_INIT);
                    r_idx   <= '0;
                    r_state <= (w_nlen == '0) ? S_RESOLVE : S_HASH;
                end
                S_HASH: begin
                    // bucket read is issued in the final cycle
                    if (r_idx == r_klen) begin
                        r_state <= S_BWAIT;
                    end else begin
                        r_h   <= w_hnext;
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_BWAIT: begin
                    if (r_bq.valid) begin
                        r_cur   <= r_bq.head;
                        r_state <= S_SCMP;
                    end else begin
                        r_state <= S_RESOLVE;
                    end
                end
                S_SCMP: begin
                    if (w_match) begin
                        r_found <= 1'b1;
                        r_slot  <= r_cur;
                        r_sent  <= r_sq;
                        r_state <= S_RESOLVE;
                    end else if (r_sq.cvalid) begin
                        r_cur <= r_sq.cnext;
                    end else begin
                        r_state <= S_RESOLVE;
                    end
                end
                S_RESOLVE: begin
                    if (w_res_go) begin
                        if (r_mode != M_FLUSH) begin
                            r_ovalid <= 1'b1;
                            r_out    <= w_res_out;
                        end
                        if (w_insert) begin
                            r_keys_used <= r_keys_used + 1'b1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                S_RDADR: begin
                    r_state <= S_RDCHK;
                end
                S_RDCHK: begin
                    if (w_ofree) begin
                        r_ovalid <= 1'b1;
                        r_out    <= w_rd_out;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> rtl/kli_checker.sv
module kli_props (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input kli_pkg::t_in  i_in_data,
    input logic          o_in_ready,
    input logic          o_out_valid,
    input kli_pkg::t_out o_out_data,
    input logic          i_out_ready
);

    // a waiting result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status == kli_pkg::ST_EMPTY ||
                        o_out_data.status == kli_pkg::ST_FULL ||
                        o_out_data.status == kli_pkg::ST_NOTFOUND ||
                        o_out_data.status == kli_pkg::ST_RANGE)
        |-> o_out_data.slot == 8'd0 && o_out_data.occ_count == 7'd0 &&
            o_out_data.line_number == 16'd0 && !o_out_data.overflowed)
        else $error("fields set on a miss");

    a_line_read_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != kli_pkg::ST_READOK
        |-> o_out_data.line_number == 16'd0)
        else $error("line number outside a read");

    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.overflowed
        |-> o_out_data.occ_count == 7'(kli_pkg::DEF_OCC_MAX))
        else $error("overflow below the cap");

endmodule

bind keyword_line_indexer kli_props u_kli_props (.*);
